### hw/rtl/spi_mbe_pkg.sv
// Shared types and constants for the SPI master byte engine.
// No dependencies; used by spi_mbe_core, spi_mbe_obuf and the top level.
`default_nettype none

package spi_mbe_pkg;

    // Command codes carried in the mode field of each tick
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_RECV = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_SPI_MODE    = 3'd0;
    localparam logic [2:0] REG_HALF_PERIOD = 3'd1;
    localparam logic [2:0] REG_MOSI_EN     = 3'd2;
    localparam logic [2:0] REG_MISO_EN     = 3'd3;
    localparam logic [2:0] REG_CS_EN       = 3'd4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Byte shifted out by a receive-only command
    localparam logic [7:0] RECV_ONLY_BYTE = 8'hFF;

    // Engine phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_LEAD  = 5'b00010,
        PH_BIT_A = 5'b00100,
        PH_BIT_B = 5'b01000,
        PH_TAIL  = 5'b10000
    } t_phase;

    // Configuration register set
    typedef struct packed {
        logic [1:0]  spi_mode;
        logic [15:0] half_period;
        logic        mosi_enable;
        logic        miso_enable;
        logic        cs_enable;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       cs_n;
        logic       busy_res;
        logic       cmd_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/spi_mbe_core.sv
// SPI timing engine: phase, bit and tick state plus the per-tick next-state logic.
// Depends on spi_mbe_pkg.
`default_nettype none

module spi_mbe_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  spi_mbe_pkg::t_cfg     i_cfg,
    input  wire  [1:0]            i_mode,
    input  wire  [7:0]            i_tx_byte,
    input  wire                   i_last_byte,
    input  wire                   i_miso_level,
    output spi_mbe_pkg::t_result  o_res
);

    spi_mbe_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_bit_idx, n_bit_idx;
    logic [7:0]  r_tx_shift, n_tx_shift;
    logic [7:0]  r_rx_shift, n_rx_shift;
    logic [15:0] r_tick, n_tick;
    logic        r_cs_low, n_cs_low;
    logic        r_release, n_release;

    logic [15:0] hp;
    logic [15:0] tick_inc;
    logic        expire;
    logic        taken;
    logic        rx_valid;
    logic        cpol;
    logic        cpha;
    logic        in_bit;
    logic        sck_active;

    // Zero half period behaves as one tick
    assign hp       = (i_cfg.half_period == '0) ? 16'd1 : i_cfg.half_period;
    assign tick_inc = r_tick + 16'd1;
    assign expire   = (tick_inc >= hp) || (tick_inc == '0);

    // Next-state logic for one tick
    always_comb begin
        n_phase    = r_phase;
        n_bit_idx  = r_bit_idx;
        n_tx_shift = r_tx_shift;
        n_rx_shift = r_rx_shift;
        n_tick     = r_tick;
        n_cs_low   = r_cs_low;
        n_release  = r_release;
        taken      = 1'b0;
        rx_valid   = 1'b0;

        if (r_phase == spi_mbe_pkg::PH_IDLE) begin
            if (i_mode == spi_mbe_pkg::CMD_SEND || i_mode == spi_mbe_pkg::CMD_RECV) begin
                taken      = 1'b1;
                n_tx_shift = (i_mode == spi_mbe_pkg::CMD_SEND) ? i_tx_byte
                                                               : spi_mbe_pkg::RECV_ONLY_BYTE;
                n_rx_shift = '0;
                n_bit_idx  = 3'd7;
                n_release  = i_last_byte;
                n_tick     = '0;
                if (i_cfg.cs_enable && !r_cs_low) begin
                    n_cs_low = 1'b1;
                    n_phase  = spi_mbe_pkg::PH_LEAD;
                end else begin
                    n_phase  = spi_mbe_pkg::PH_BIT_A;
                end
            end
        end else begin
            n_tick = tick_inc;
            if (expire) begin
                n_tick = '0;
                unique case (r_phase)
                    spi_mbe_pkg::PH_LEAD: begin
                        n_phase = spi_mbe_pkg::PH_BIT_A;
                    end
                    spi_mbe_pkg::PH_BIT_A: begin
                        n_phase = spi_mbe_pkg::PH_BIT_B;
                    end
                    spi_mbe_pkg::PH_BIT_B: begin
                        // sample MISO at the end of the second half
                        if (i_cfg.miso_enable && i_miso_level) begin
                            n_rx_shift[r_bit_idx] = 1'b1;
                        end
                        if (r_bit_idx == 3'd0) begin
                            rx_valid  = 1'b1;
                            n_bit_idx = 3'd7;
                            n_phase   = (r_release && r_cs_low) ? spi_mbe_pkg::PH_TAIL
                                                                : spi_mbe_pkg::PH_IDLE;
                            n_release = 1'b0;
                        end else begin
                            n_bit_idx = r_bit_idx - 3'd1;
                            n_phase   = spi_mbe_pkg::PH_BIT_A;
                        end
                    end
                    spi_mbe_pkg::PH_TAIL: begin
                        n_cs_low = 1'b0;
                        n_phase  = spi_mbe_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase = spi_mbe_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Pin levels after this tick
    assign cpol   = i_cfg.spi_mode[1];
    assign cpha   = i_cfg.spi_mode[0];
    assign in_bit = (n_phase == spi_mbe_pkg::PH_BIT_A) || (n_phase == spi_mbe_pkg::PH_BIT_B);
    assign sck_active = (n_phase == spi_mbe_pkg::PH_BIT_A) ? cpha : !cpha;

    always_comb begin
        o_res.sck_level  = (in_bit && sck_active) ? !cpol : cpol;
        o_res.mosi_level = in_bit && i_cfg.mosi_enable && n_tx_shift[n_bit_idx];
        o_res.cs_n       = !(i_cfg.cs_enable && n_cs_low);
        o_res.busy_res   = (n_phase != spi_mbe_pkg::PH_IDLE);
        o_res.cmd_taken  = taken;
        o_res.rx_valid   = rx_valid;
        o_res.rx_byte    = rx_valid ? n_rx_shift : 8'd0;
    end

    // State registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= spi_mbe_pkg::PH_IDLE;
            r_bit_idx  <= 3'd7;
            r_tx_shift <= '0;
            r_rx_shift <= '0;
            r_tick     <= '0;
            r_cs_low   <= 1'b0;
            r_release  <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_idx  <= n_bit_idx;
            r_tx_shift <= n_tx_shift;
            r_rx_shift <= n_rx_shift;
            r_tick     <= n_tick;
            r_cs_low   <= n_cs_low;
            r_release  <= n_release;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spi_mbe_obuf.sv
// Result register with a skid stage so the input side can push one more result under a stall.
// Depends on spi_mbe_pkg.
`default_nettype none

module spi_mbe_obuf (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  spi_mbe_pkg::t_result  i_res,
    output logic                  o_can_push,
    output logic                  o_valid,
    input  wire                   i_ready,
    output spi_mbe_pkg::t_result  o_res
);

    logic                 r_out_v;
    logic                 r_skid_v;
    spi_mbe_pkg::t_result r_out;
    spi_mbe_pkg::t_result r_skid;
    logic                 out_free;

    assign o_can_push = !r_skid_v;
    assign o_valid    = r_out_v;
    assign o_res      = r_out;
    assign out_free   = !r_out_v || i_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spi_master_byte_engine_top.sv
// Top level of the SPI master byte engine: configuration registers, engine, result buffer.
// Depends on spi_mbe_pkg, spi_mbe_core and spi_mbe_obuf.
// A tick's result is registered in the result buffer: its output register, or its skid register.
// Throughput: one tick per cycle while the skid register is empty; single next-state pass per tick.
// A two-deep result buffer keeps input ready high until its skid register fills under a stall.
// Reset (synchronous, active low) idles the engine, releases chip select and
// loads the register defaults: mode 0, half period 1, MOSI/MISO/CS enabled.
`default_nettype none

module spi_master_byte_engine_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration write port
    input  wire        i_cfg_wr_en,
    input  wire  [spi_mbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [spi_mbe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // tick input
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [1:0] i_mode,
    input  wire  [7:0] i_tx_byte,
    input  wire        i_last_byte,
    input  wire        i_miso_level,
    // result output
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_sck_level,
    output logic       o_mosi_level,
    output logic       o_cs_n,
    output logic       o_busy_res,
    output logic       o_cmd_taken,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte
);

    spi_mbe_pkg::t_cfg    r_cfg;
    spi_mbe_pkg::t_result core_res;
    spi_mbe_pkg::t_result out_res;
    logic                 step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spi_mode    <= 2'd0;
            r_cfg.half_period <= 16'd1;
            r_cfg.mosi_enable <= 1'b1;
            r_cfg.miso_enable <= 1'b1;
            r_cfg.cs_enable   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                spi_mbe_pkg::REG_SPI_MODE:    r_cfg.spi_mode    <= i_cfg_wdata[1:0];
                spi_mbe_pkg::REG_HALF_PERIOD: r_cfg.half_period <= i_cfg_wdata;
                spi_mbe_pkg::REG_MOSI_EN:     r_cfg.mosi_enable <= i_cfg_wdata[0];
                spi_mbe_pkg::REG_MISO_EN:     r_cfg.miso_enable <= i_cfg_wdata[0];
                spi_mbe_pkg::REG_CS_EN:       r_cfg.cs_enable   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // one transfer on the input channel is one engine tick
    assign step = i_in_valid && o_in_ready;

    spi_mbe_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cfg        (r_cfg),
        .i_mode       (i_mode),
        .i_tx_byte    (i_tx_byte),
        .i_last_byte  (i_last_byte),
        .i_miso_level (i_miso_level),
        .o_res        (core_res)
    );

    spi_mbe_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_res      (core_res),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    assign o_sck_level  = out_res.sck_level;
    assign o_mosi_level = out_res.mosi_level;
    assign o_cs_n       = out_res.cs_n;
    assign o_busy_res   = out_res.busy_res;
    assign o_cmd_taken  = out_res.cmd_taken;
    assign o_rx_valid   = out_res.rx_valid;
    assign o_rx_byte    = out_res.rx_byte;

endmodule

`default_nettype wire

### tb/tb_spi_master_byte_engine_top.sv
// Self-checking testbench for spi_master_byte_engine_top: queued tick driver, result monitor
// and a tick-level model of the SPI engine pins. Depends on spi_mbe_pkg and the RTL top.
module tb_spi_master_byte_engine_top;

    // Mode value with no meaning of its own; the engine treats it as a plain tick
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_SETTINGS = 12;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       miso_level;
    } t_spi_tick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic  [2:0] i_cfg_idx = spi_mbe_pkg::REG_SPI_MODE;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic  [1:0] i_mode = spi_mbe_pkg::CMD_TICK;
    logic  [7:0] i_tx_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_miso_level = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_sck_level;
    logic        o_mosi_level;
    logic        o_cs_n;
    logic        o_busy_res;
    logic        o_cmd_taken;
    logic        o_rx_valid;
    logic  [7:0] o_rx_byte;

    spi_master_byte_engine_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_tx_byte    (i_tx_byte),
        .i_last_byte  (i_last_byte),
        .i_miso_level (i_miso_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sck_level  (o_sck_level),
        .o_mosi_level (o_mosi_level),
        .o_cs_n       (o_cs_n),
        .o_busy_res   (o_busy_res),
        .o_cmd_taken  (o_cmd_taken),
        .o_rx_valid   (o_rx_valid),
        .o_rx_byte    (o_rx_byte)
    );

    always #5 i_clk = ~i_clk;

    // Model copy of the registers and the engine state
    spi_mbe_pkg::t_cfg   reg_copy = '{spi_mode: 2'd0, half_period: 16'd1, mosi_enable: 1'b1,
                                      miso_enable: 1'b1, cs_enable: 1'b1};
    spi_mbe_pkg::t_phase eng_phase = spi_mbe_pkg::PH_IDLE;
    logic  [2:0] eng_bit = 3'd7;
    logic  [7:0] eng_tx = '0;
    logic  [7:0] eng_rx = '0;
    logic [15:0] eng_ticks = '0;
    logic        eng_cs_low = 1'b0;
    logic        eng_release = 1'b0;

    t_spi_tick             tick_queue[$];
    spi_mbe_pkg::t_result  pins_due[$];
    t_spi_tick             drv_item;
    spi_mbe_pkg::t_result  want;
    int          send_idle_pct = 6;
    int          recv_idle_pct = 46;
    int          mismatches = 0;
    int          ticks_queued = 0;
    int          ticks_sent = 0;
    int          taken_seen = 0;
    int          bytes_seen = 0;

    // Advance the engine model by one tick and return the pin levels after it
    function automatic spi_mbe_pkg::t_result advance_engine(t_spi_tick t);
        spi_mbe_pkg::t_result r;
        logic [15:0] hp;
        logic        active;
        r = '0;
        hp = (reg_copy.half_period == 16'd0) ? 16'd1 : reg_copy.half_period;
        if (eng_phase == spi_mbe_pkg::PH_IDLE) begin
            if (t.mode == spi_mbe_pkg::CMD_SEND || t.mode == spi_mbe_pkg::CMD_RECV) begin
                r.cmd_taken = 1'b1;
                eng_tx = (t.mode == spi_mbe_pkg::CMD_SEND) ? t.tx_byte
                                                           : spi_mbe_pkg::RECV_ONLY_BYTE;
                eng_rx = '0;
                eng_bit = 3'd7;
                eng_release = t.last_byte;
                eng_ticks = '0;
                if (reg_copy.cs_enable && !eng_cs_low) begin
                    eng_cs_low = 1'b1;
                    eng_phase = spi_mbe_pkg::PH_LEAD;
                end else begin
                    eng_phase = spi_mbe_pkg::PH_BIT_A;
                end
            end
        end else begin
            eng_ticks = eng_ticks + 16'd1;
            if (eng_ticks >= hp || eng_ticks == 16'd0) begin
                eng_ticks = '0;
                case (eng_phase)
                    spi_mbe_pkg::PH_LEAD: eng_phase = spi_mbe_pkg::PH_BIT_A;
                    spi_mbe_pkg::PH_BIT_A: eng_phase = spi_mbe_pkg::PH_BIT_B;
                    spi_mbe_pkg::PH_BIT_B: begin
                        if (reg_copy.miso_enable && t.miso_level)
                            eng_rx[eng_bit] = 1'b1;
                        if (eng_bit == 3'd0) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = eng_rx;
                            eng_bit = 3'd7;
                            eng_phase = (eng_release && eng_cs_low) ? spi_mbe_pkg::PH_TAIL
                                                                    : spi_mbe_pkg::PH_IDLE;
                            eng_release = 1'b0;
                        end else begin
                            eng_bit = eng_bit - 3'd1;
                            eng_phase = spi_mbe_pkg::PH_BIT_A;
                        end
                    end
                    spi_mbe_pkg::PH_TAIL: begin
                        eng_cs_low = 1'b0;
                        eng_phase = spi_mbe_pkg::PH_IDLE;
                    end
                    default: eng_phase = spi_mbe_pkg::PH_IDLE;
                endcase
            end
        end

        // Pin levels after this tick
        r.sck_level = reg_copy.spi_mode[1];
        r.mosi_level = 1'b0;
        if (eng_phase == spi_mbe_pkg::PH_BIT_A || eng_phase == spi_mbe_pkg::PH_BIT_B) begin
            active = (eng_phase == spi_mbe_pkg::PH_BIT_A) ? reg_copy.spi_mode[0]
                                                          : !reg_copy.spi_mode[0];
            if (active)
                r.sck_level = !reg_copy.spi_mode[1];
            if (reg_copy.mosi_enable)
                r.mosi_level = eng_tx[eng_bit];
        end
        r.cs_n = !(reg_copy.cs_enable && eng_cs_low);
        r.busy_res = (eng_phase != spi_mbe_pkg::PH_IDLE);
        return r;
    endfunction

    task automatic queue_tick(input logic [1:0] m, input logic [7:0] tx, input logic last,
                              input logic miso);
        tick_queue.push_back('{mode: m, tx_byte: tx, last_byte: last, miso_level: miso});
        ticks_queued++;
    endtask

    // One command followed by roughly enough ticks to finish the byte,
    // with the odd stray command or unused mode in between
    task automatic queue_frame(input int hp_eff);
        int         n;
        logic [1:0] m;
        m = ($urandom_range(9) < 7) ? spi_mbe_pkg::CMD_SEND : spi_mbe_pkg::CMD_RECV;
        queue_tick(m, 8'($urandom_range(255)), $urandom_range(9) < 4,
                   1'($urandom_range(1)));
        n = 18 * hp_eff + int'($urandom_range(2));
        repeat (n) begin
            case ($urandom_range(39))
                0: m = spi_mbe_pkg::CMD_SEND;
                1: m = spi_mbe_pkg::CMD_RECV;
                2: m = CMD_UNUSED;
                default: m = spi_mbe_pkg::CMD_TICK;
            endcase
            queue_tick(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        end
    endtask

    // Register write; only called once every queued tick has come back as a result
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            spi_mbe_pkg::REG_SPI_MODE:    reg_copy.spi_mode = data[1:0];
            spi_mbe_pkg::REG_HALF_PERIOD: reg_copy.half_period = data;
            spi_mbe_pkg::REG_MOSI_EN:     reg_copy.mosi_enable = data[0];
            spi_mbe_pkg::REG_MISO_EN:     reg_copy.miso_enable = data[0];
            spi_mbe_pkg::REG_CS_EN:       reg_copy.cs_enable = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Sender stays quiet until every queued tick has come back as a result
    task automatic wait_drained();
        while (tick_queue.size() != 0 || i_in_valid || pins_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Tick driver: predicts each accepted transfer, then presents the next queued tick
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pins_due.push_back(advance_engine({i_mode, i_tx_byte, i_last_byte,
                                                   i_miso_level}));
                ticks_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = tick_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= drv_item.mode;
                    i_tx_byte <= drv_item.tx_byte;
                    i_last_byte <= drv_item.last_byte;
                    i_miso_level <= drv_item.miso_level;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     got_val);
            mismatches++;
        end
    endtask

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pins_due.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                mismatches++;
            end else begin
                want = pins_due.pop_front();
                cmp_field("sck_level", 8'(want.sck_level), 8'(o_sck_level));
                cmp_field("mosi_level", 8'(want.mosi_level), 8'(o_mosi_level));
                cmp_field("cs_n", 8'(want.cs_n), 8'(o_cs_n));
                cmp_field("busy_res", 8'(want.busy_res), 8'(o_busy_res));
                cmp_field("cmd_taken", 8'(want.cmd_taken), 8'(o_cmd_taken));
                cmp_field("rx_valid", 8'(want.rx_valid), 8'(o_rx_valid));
                cmp_field("rx_byte", want.rx_byte, o_rx_byte);
            end
            if (o_cmd_taken === 1'b1)
                taken_seen++;
            if (o_rx_valid === 1'b1)
                bytes_seen++;
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stimulus
    initial begin
        int hp_plan[N_SETTINGS];
        int hp_eff;
        int phase_start;
        bit paused;
        hp_plan = '{1, 1, 2, 1, 3, 1, 2, 0, 1, 4, 1, 2};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Receive-only byte at reset settings, with refused and unused commands while busy
        queue_tick(spi_mbe_pkg::CMD_RECV, 8'h00, 1'b0, 1'b1);
        for (int k = 0; k < 17; k++) begin
            if (k == 3)
                queue_tick(spi_mbe_pkg::CMD_SEND, 8'hFF, 1'b1, k[0]);
            else if (k == 6)
                queue_tick(CMD_UNUSED, 8'h55, 1'b0, k[0]);
            else
                queue_tick(spi_mbe_pkg::CMD_TICK, 8'h00, 1'b0, k[0]);
        end
        // Unused mode while idle, then a back-to-back last byte with chip select still low
        queue_tick(CMD_UNUSED, 8'h00, 1'b1, 1'b0);
        queue_tick(spi_mbe_pkg::CMD_SEND, 8'h00, 1'b1, 1'b1);
        queue_tick(spi_mbe_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1);
        queue_tick(spi_mbe_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0);
        wait_drained();

        // Slowest half period mid-byte, then a zero half period cuts the phase short
        write_reg(spi_mbe_pkg::REG_SPI_MODE, 16'd3);
        write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'hFFFF);
        repeat (12) queue_tick(spi_mbe_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b0,
                               1'($urandom_range(1)));
        wait_drained();
        write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'd0);
        repeat (24) queue_tick(spi_mbe_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b0,
                               1'($urandom_range(1)));
        wait_drained();

        // Random traffic over a sweep of register settings
        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p == 4) begin
                send_idle_pct = 46;
                recv_idle_pct = 6;
            end
            if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(spi_mbe_pkg::REG_SPI_MODE, 16'(p % 4));
            write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'(hp_plan[p]));
            write_reg(spi_mbe_pkg::REG_MOSI_EN, 16'(p % 5 != 4));
            write_reg(spi_mbe_pkg::REG_MISO_EN, 16'(p % 3 != 2));
            write_reg(spi_mbe_pkg::REG_CS_EN, 16'(p % 6 != 5));
            hp_eff = (hp_plan[p] == 0) ? 1 : hp_plan[p];
            phase_start = ticks_queued;
            paused = 1'b0;
            while (ticks_queued - phase_start < 40) begin
                if (p == 6 && !paused && ticks_queued - phase_start >= 20) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 80) begin
                    queue_frame(hp_eff);
                end else begin
                    repeat ($urandom_range(6, 1))
                        queue_tick(2'($urandom_range(3)), 8'($urandom_range(255)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        $display("Ran %0d ticks over %0d register settings plus the slow-clock case:",
                 ticks_sent, N_SETTINGS);
        $display("%0d commands taken, %0d bytes received", taken_seen, bytes_seen);
        if (mismatches == 0) begin
            $display("spi_master_byte_engine_top test passed");
        end else begin
            $display("spi_master_byte_engine_top test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("spi_master_byte_engine_top test failed");
        $finish;
    end

endmodule
